// File: src/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared constants, types and a helper function for the day count to
// calendar date converter.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned DAY_COUNT_BITS_DEF = 20;
  localparam int unsigned EPOCH_W            = 12;
  localparam int unsigned DAY_W              = 5;
  localparam int unsigned MONTH_W            = 4;
  localparam int unsigned YEAR_W             = 13;
  localparam int unsigned APB_ADDR_W         = 3;
  localparam int unsigned APB_DATA_W         = 32;

  localparam logic [EPOCH_W-1:0] EPOCH_RESET = 12'd1900;

  // Register index taken from the word address bit of paddr.
  localparam logic REG_EPOCH = 1'b0;

  localparam int unsigned CYCLE_DAYS    = 146097;
  localparam int unsigned CENTURY_DAYS  = 36524;
  localparam int unsigned QUAD_DAYS     = 1460;
  localparam int unsigned YEAR_DAYS     = 365;
  localparam int unsigned CYCLE_YEARS   = 400;
  localparam int unsigned CENTURY_YEARS = 100;
  localparam int unsigned QUAD_YEARS    = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CENT,
    S_QUAD,
    S_YEAR,
    S_MONTH
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic cent_step;
    logic quad_step;
    logic year_step;
    logic month_step;
    logic out_load;
  } dcc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic cent_fit;
    logic quad_fit;
    logic year_fit;
    logic month_fit;
  } dcc_status_t;

  // Length of month m (1 = January); February follows the leap flag.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: src/dcc_in_if.sv
// ----------------------------------------------------------------------------
// dcc_in_if
// Valid/ready channel carrying one day count.
// ----------------------------------------------------------------------------
interface dcc_in_if #(
  parameter int unsigned DAY_COUNT_BITS = dcc_pkg::DAY_COUNT_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [DAY_COUNT_BITS-1:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

// File: src/dcc_out_if.sv
// ----------------------------------------------------------------------------
// dcc_out_if
// Valid/ready channel carrying one calendar date.
// ----------------------------------------------------------------------------
interface dcc_out_if;
  import dcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day_of_month;
  logic [MONTH_W-1:0] month_number;
  logic [YEAR_W-1:0]  year_number;

  modport source (output valid, output day_of_month, output month_number,
                  output year_number, input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_number, output ready);
endinterface

// File: src/dcc_ctrl.sv
// ----------------------------------------------------------------------------
// dcc_ctrl
// Sequencer for the conversion: cycle division, century, four-year, year
// and month phases, plus the output valid flag.
// ----------------------------------------------------------------------------
module dcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dcc_pkg::dcc_status_t status_i,
  output dcc_pkg::dcc_cmd_t    cmd_o
);
  import dcc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DIV;
      S_DIV:   if (status_i.div_last) state_d = S_CENT;
      S_CENT:  if (!status_i.cent_fit) state_d = S_QUAD;
      S_QUAD:  if (!status_i.quad_fit) state_d = S_YEAR;
      S_YEAR:  if (!status_i.year_fit) state_d = S_MONTH;
      S_MONTH: if (!status_i.month_fit && slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DIV:   cmd_o.div_step   = 1'b1;
      S_CENT:  cmd_o.cent_step  = status_i.cent_fit;
      S_QUAD:  cmd_o.quad_step  = status_i.quad_fit;
      S_YEAR:  cmd_o.year_step  = status_i.year_fit;
      S_MONTH: begin
        cmd_o.month_step = status_i.month_fit;
        cmd_o.out_load   = !status_i.month_fit && slot_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/dcc_datapath.sv
// ----------------------------------------------------------------------------
// dcc_datapath
// Remaining day count, year, year-within-400 residue and month registers,
// with the subtract and compare logic for each phase and the result register.
// ----------------------------------------------------------------------------
module dcc_datapath #(
  parameter int unsigned DAY_COUNT_BITS = dcc_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dcc_pkg::dcc_cmd_t             cmd_i,
  output dcc_pkg::dcc_status_t          status_o,
  input  logic [DAY_COUNT_BITS-1:0]     day_count_i,
  input  logic [dcc_pkg::EPOCH_W-1:0]   epoch_i,
  output logic [dcc_pkg::DAY_W-1:0]     day_of_month_o,
  output logic [dcc_pkg::MONTH_W-1:0]   month_number_o,
  output logic [dcc_pkg::YEAR_W-1:0]    year_number_o
);
  import dcc_pkg::*;

  logic [DAY_COUNT_BITS-1:0] d_q, d_d;
  logic [YEAR_W-1:0]         y_q, y_d;
  logic [EPOCH_W-1:0]        r_q, r_d;
  logic [MONTH_W-1:0]        m_q, m_d;

  logic [DAY_W-1:0]   dom_q;
  logic [MONTH_W-1:0] mon_q;
  logic [YEAR_W-1:0]  yr_q;

  logic [31:0]        d_ext;
  logic               div_fit;
  logic               mod_fit;
  logic [8:0]         r400;
  logic [6:0]         r100;
  logic [6:0]         c_off;
  logic [9:0]         c_sum;
  logic [31:0]        cent_len;
  logic [1:0]         q_off;
  logic [7:0]         q_s100;
  logic [9:0]         q_s400;
  logic [31:0]        quad_len;
  logic               leap;
  logic [31:0]        year_len;
  logic [31:0]        mon_len;
  logic [EPOCH_W-1:0] r_p100;
  logic [EPOCH_W-1:0] r_p4;
  logic [EPOCH_W-1:0] r_p1;

  // Whole 400-year cycles come off the day count one per cycle, while the
  // epoch residue modulo 400 is reduced in the same pass.
  assign d_ext   = 32'(d_q);
  assign div_fit = d_ext >= 32'(CYCLE_DAYS);
  assign mod_fit = r_q >= EPOCH_W'(CYCLE_YEARS);

  assign r400 = r_q[8:0];

  always_comb begin
    if (r400 >= 9'd300) begin
      r100 = 7'(r400 - 9'd300);
    end else if (r400 >= 9'd200) begin
      r100 = 7'(r400 - 9'd200);
    end else if (r400 >= 9'd100) begin
      r100 = 7'(r400 - 9'd100);
    end else begin
      r100 = 7'(r400);
    end
  end

  // The next 100 years hold one century year; it is short unless it is a
  // multiple of 400.
  assign c_off    = (r100 == 7'd0) ? 7'd0 : 7'(7'd100 - r100);
  assign c_sum    = 10'(r400) + 10'(c_off);
  assign cent_len = ((c_sum == 10'd0) || (c_sum == 10'd400)) ?
                    32'(CENTURY_DAYS + 1) : 32'(CENTURY_DAYS);

  // The next four years hold one multiple of four; it is a common year only
  // when it is a century not divisible by 400.
  assign q_off    = 2'(2'd0 - r400[1:0]);
  assign q_s100   = 8'(r100) + 8'(q_off);
  assign q_s400   = 10'(r400) + 10'(q_off);
  assign quad_len = (((q_s100 == 8'd0) || (q_s100 == 8'd100)) &&
                     !((q_s400 == 10'd0) || (q_s400 == 10'd400))) ?
                    32'(QUAD_DAYS) : 32'(QUAD_DAYS + 1);

  assign leap     = (r400 == 9'd0) || ((r400[1:0] == 2'd0) && (r100 != 7'd0));
  assign year_len = leap ? 32'(YEAR_DAYS + 1) : 32'(YEAR_DAYS);
  assign mon_len  = 32'(month_days(m_q, leap));

  always_comb begin
    r_p100 = r_q + EPOCH_W'(CENTURY_YEARS);
    if (r_p100 >= EPOCH_W'(CYCLE_YEARS)) r_p100 = r_p100 - EPOCH_W'(CYCLE_YEARS);
    r_p4 = r_q + EPOCH_W'(QUAD_YEARS);
    if (r_p4 >= EPOCH_W'(CYCLE_YEARS)) r_p4 = r_p4 - EPOCH_W'(CYCLE_YEARS);
    r_p1 = r_q + EPOCH_W'(1);
    if (r_p1 >= EPOCH_W'(CYCLE_YEARS)) r_p1 = r_p1 - EPOCH_W'(CYCLE_YEARS);
  end

  assign status_o.div_last  = !div_fit && !mod_fit;
  assign status_o.cent_fit  = d_ext >= cent_len;
  assign status_o.quad_fit  = d_ext >= quad_len;
  assign status_o.year_fit  = d_ext >= year_len;
  assign status_o.month_fit = d_ext >= mon_len;

  always_comb begin
    d_d = d_q;
    y_d = y_q;
    r_d = r_q;
    m_d = m_q;
    if (cmd_i.load) begin
      d_d = day_count_i;
      y_d = YEAR_W'(epoch_i);
      r_d = epoch_i;
      m_d = MONTH_W'(1);
    end else if (cmd_i.div_step) begin
      if (div_fit) begin
        d_d = d_q - DAY_COUNT_BITS'(CYCLE_DAYS);
        y_d = y_q + YEAR_W'(CYCLE_YEARS);
      end
      if (mod_fit) r_d = r_q - EPOCH_W'(CYCLE_YEARS);
    end else if (cmd_i.cent_step) begin
      d_d = d_q - DAY_COUNT_BITS'(cent_len);
      y_d = y_q + YEAR_W'(CENTURY_YEARS);
      r_d = r_p100;
    end else if (cmd_i.quad_step) begin
      d_d = d_q - DAY_COUNT_BITS'(quad_len);
      y_d = y_q + YEAR_W'(QUAD_YEARS);
      r_d = r_p4;
    end else if (cmd_i.year_step) begin
      d_d = d_q - DAY_COUNT_BITS'(year_len);
      y_d = y_q + YEAR_W'(1);
      r_d = r_p1;
    end else if (cmd_i.month_step) begin
      d_d = d_q - DAY_COUNT_BITS'(mon_len);
      m_d = m_q + MONTH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
      y_q <= '0;
      r_q <= '0;
      m_q <= '0;
    end else begin
      d_q <= d_d;
      y_q <= y_d;
      r_q <= r_d;
      m_q <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      dom_q <= DAY_W'(d_q) + DAY_W'(1);
      mon_q <= m_q;
      yr_q  <= y_q;
    end
  end

  assign day_of_month_o = dom_q;
  assign month_number_o = mon_q;
  assign year_number_o  = yr_q;

endmodule

// File: src/day_count_to_calendar_date_top.sv
// Sequence: the result follows the cycle division, century, four-year, year
// and month phases, plus any wait for a free output register; the 400-year
// and epoch reduction goes on while the day count or the epoch residue still
// holds a whole 400-year span. Throughput: one item at a time; the next input is
// taken the cycle after the result moves to the output register.
// Reset: rst_ni is asynchronous, active low; epoch_year returns to 1900.
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_top
// Converts a day count since January 1 of a programmable epoch year into a
// Gregorian day of month, month and year.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date_top #(
  parameter int unsigned DAY_COUNT_BITS = dcc_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dcc_in_if.sink                             in_i,
  dcc_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dcc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import dcc_pkg::*;

  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               reg_sel;
  dcc_cmd_t           cmd;
  dcc_status_t        status;

  assign reg_sel = (paddr[2] == REG_EPOCH);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(epoch_q) : '0;

  always_comb begin
    epoch_d = epoch_q;
    if (psel && penable && pwrite && reg_sel) epoch_d = pwdata[EPOCH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EPOCH_RESET;
    end else begin
      epoch_q <= epoch_d;
    end
  end

  dcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dcc_datapath #(
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .day_count_i    (in_i.day_count),
    .epoch_i        (epoch_q),
    .day_of_month_o (out_o.day_of_month),
    .month_number_o (out_o.month_number),
    .year_number_o  (out_o.year_number)
  );

endmodule

// File: verif/calendar_date_checker.sv
// ----------------------------------------------------------------------------
// calendar_date_checker
// Watches the day count channel, the date channel and the register port of
// the day count to calendar date converter. Each accepted day count is turned
// into the expected Gregorian date under the epoch year in force. Each date
// transfer is compared with the oldest expected date.
// ----------------------------------------------------------------------------
module calendar_date_checker
  import dcc_pkg::*;
#(
  parameter int unsigned DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [DAY_COUNT_BITS-1:0] in_day_count_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [DAY_W-1:0]          out_day_i,
  input  logic [MONTH_W-1:0]        out_month_i,
  input  logic [YEAR_W-1:0]         out_year_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [APB_ADDR_W-1:0]     paddr_i,
  input  logic [APB_DATA_W-1:0]     pwdata_i,
  output int unsigned               mismatches_o,
  output int unsigned               dates_pending_o
);

  localparam logic [APB_ADDR_W-1:0] EPOCH_ADDR = {REG_EPOCH, 2'b00};
  localparam int unsigned DAYS_PER_400Y = 146097;
  localparam int unsigned MONTH_SPAN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  date_t              dates_due[$];
  logic [EPOCH_W-1:0] epoch_year;

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic date_t gregorian_date_of(input logic [DAY_COUNT_BITS-1:0] count,
                                              input logic [EPOCH_W-1:0] epoch);
    int unsigned rest;
    int unsigned year;
    int unsigned month;
    int unsigned span;
    date_t       date;
    rest  = count;
    year  = epoch;
    // The leap pattern repeats every 400 years, so whole cycles go at once.
    year += 400 * (rest / DAYS_PER_400Y);
    rest  = rest % DAYS_PER_400Y;
    span  = leap_year(year) ? 366 : 365;
    while (rest >= span) begin
      rest -= span;
      year++;
      span = leap_year(year) ? 366 : 365;
    end
    month = 1;
    span  = MONTH_SPAN[0];
    while (rest >= span && month < 12) begin
      rest -= span;
      month++;
      span = (month == 2 && leap_year(year)) ? 29 : MONTH_SPAN[month-1];
    end
    date.day   = DAY_W'(rest + 1);
    date.month = MONTH_W'(month);
    date.year  = YEAR_W'(year);
    return date;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_t want;
    if (!rst_ni) begin
      epoch_year = EPOCH_RESET;
      dates_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        dates_due.push_back(gregorian_date_of(in_day_count_i, epoch_year));
      end
      if (out_valid_i && out_ready_i) begin
        if (dates_due.size() == 0) begin
          $error("date %0d-%0d-%0d arrived with no day count waiting",
                 out_year_i, out_month_i, out_day_i);
          mismatches_o++;
        end else begin
          want = dates_due.pop_front();
          if (out_day_i !== want.day) begin
            $error("day_of_month: expected %0d, got %0d", want.day, out_day_i);
            mismatches_o++;
          end
          if (out_month_i !== want.month) begin
            $error("month_number: expected %0d, got %0d", want.month, out_month_i);
            mismatches_o++;
          end
          if (out_year_i !== want.year) begin
            $error("year_number: expected %0d, got %0d", want.year, out_year_i);
            mismatches_o++;
          end
        end
      end
      // Writes only happen while no conversion is in flight, so the order
      // against the input transfer above does not matter.
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == EPOCH_ADDR) begin
        epoch_year = pwdata_i[EPOCH_W-1:0];
      end
    end
    dates_pending_o = dates_due.size();
  end

endmodule

// File: verif/tb_day_count_to_calendar_date_top.sv
// ----------------------------------------------------------------------------
// tb_day_count_to_calendar_date_top
// Drives day counts into the converter under several epoch years: a directed
// set of calendar landmarks first, then random counts biased toward month,
// year and 400-year boundaries and the top of the range. The sender works in
// bursts and the receiver stalls on its own pattern, with one long hold-off.
// The checker beside the block predicts every date and counts mismatches.
// ----------------------------------------------------------------------------
module tb_day_count_to_calendar_date_top;
  import dcc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned DAY_BITS     = DAY_COUNT_BITS_DEF;
  localparam int unsigned DAY_MAX      = (1 << DAY_BITS) - 1;
  localparam int unsigned PHASE_ITEMS  = 155;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned HOLD_AFTER   = 60;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [APB_ADDR_W-1:0] EPOCH_ADDR = {REG_EPOCH, 2'b00};

  // Landmarks for the reset epoch of 1900: month ends, the non-leap 1900
  // February, leap days of 1904 and 2000, the 400-year boundary, and bit
  // patterns up to the largest count.
  localparam int unsigned LANDMARK_DAYS [18] = '{
    0, 30, 31, 58, 59, 364, 365, 1519, 36523, 36524, 36583, 36888,
    146096, 146097, 'h55555, 'hAAAAA, 'h80000, 'hFFFFF
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           mismatches;
  int unsigned           dates_pending;
  int unsigned           burst_left;

  dcc_in_if #(.DAY_COUNT_BITS(DAY_BITS)) in_ch ();
  dcc_out_if                             out_ch ();

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  day_count_to_calendar_date_top #(
    .DAY_COUNT_BITS(DAY_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  calendar_date_checker #(
    .DAY_COUNT_BITS(DAY_BITS)
  ) date_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .in_day_count_i  (in_ch.day_count),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_day_i       (out_ch.day_of_month),
    .out_month_i     (out_ch.month_number),
    .out_year_i      (out_ch.year_number),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .mismatches_o    (mismatches),
    .dates_pending_o (dates_pending)
  );

  function automatic logic [DAY_BITS-1:0] random_day_count();
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      pick = $urandom_range(0, DAY_MAX);
    end else if (kind < 60) begin
      pick = $urandom_range(0, 3000);
    end else if (kind < 80) begin
      // Around a 400-year boundary, on either side.
      pick = $urandom_range(0, 7) * CYCLE_DAYS + $urandom_range(0, 1600);
      if (pick >= 800) pick -= 800;
      if (pick > DAY_MAX) pick = DAY_MAX;
    end else begin
      pick = DAY_MAX - $urandom_range(0, 2000);
    end
    return DAY_BITS'(pick);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_day(input logic [DAY_BITS-1:0] count);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                              : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.day_count <= count;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_epoch(input logic [EPOCH_W-1:0] year);
    logic [APB_DATA_W-1:0] junk;
    junk    = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EPOCH_ADDR;
    pwdata  <= {junk[APB_DATA_W-1:EPOCH_W], year};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned beat;
    int unsigned taken;
    int unsigned hold_left;
    mode_left = 0;
    beat      = 0;
    taken     = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      beat++;
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (beat % 4 == 0);
        endcase
      end
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        taken++;
        // One long hold-off lets the sender back up into the block.
        if (taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
    end
  end

  initial begin : stimulus
    logic [EPOCH_W-1:0] epoch_plan [PHASES];
    epoch_plan[0] = EPOCH_RESET;
    epoch_plan[1] = '0;
    epoch_plan[2] = '1;
    epoch_plan[3] = 12'd2000;
    epoch_plan[4] = EPOCH_W'($urandom_range(0, 4095));
    epoch_plan[5] = 12'd1;
    burst_left = 0;
    in_ch.valid     <= 1'b0;
    in_ch.day_count <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (LANDMARK_DAYS[i]) send_day(DAY_BITS'(LANDMARK_DAYS[i]));

    for (int p = 0; p < PHASES; p++) begin
      // The first phase keeps the epoch that reset left behind.
      if (p != 0) begin
        in_ch.valid <= 1'b0;
        while (dates_pending != 0) @(negedge clk_i);
        write_epoch(epoch_plan[p]);
      end
      repeat (PHASE_ITEMS) send_day(random_day_count());
    end

    in_ch.valid <= 1'b0;
    while (dates_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && dates_pending == 0) begin
      $display("tb_day_count_to_calendar_date_top: PASS");
    end else begin
      $display("tb_day_count_to_calendar_date_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("tb_day_count_to_calendar_date_top: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
src/dcc_pkg.sv
src/dcc_in_if.sv
src/dcc_out_if.sv
src/dcc_ctrl.sv
src/dcc_datapath.sv
src/day_count_to_calendar_date_top.sv
verif/calendar_date_checker.sv
verif/tb_day_count_to_calendar_date_top.sv
